FILE: hdl/kmst_pkg.sv
// ============================================================================
// kmst_pkg
// Shared types and constants of the minimum spanning tree unit.
// ============================================================================
package kmst_pkg;

    // Fixed widths of the vertex ports and of the configuration register.
    localparam int VERT_W = 5;
    localparam int CFG_W  = 6;
    // Vertex capacity; the vertex ports are sized for exactly this many.
    localparam int MAX_VERTICES = 32;
    // Compare width for vertex numbers against the vertex count.
    localparam int CMP_W  = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    typedef struct packed {
        logic load;
        logic start;
        logic cfg_we;
        logic sweep;
        logic list;
        logic rd_i;
        logic cap_i;
        logic scan;
        logic wr_best;
        logic wr_edge_i;
        logic next_i;
        logic uf_init;
        logic rd_k;
        logic cap_k;
        logic find_a;
        logic find_b;
        logic unite;
        logic take;
        logic next_k;
        logic emit_held;
        logic emit_final;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic sort_more;
        logic scan_done;
        logic need_swap;
        logic edges_left;
        logic root_found;
        logic roots_differ;
        logic have_held;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hdl/kmst_ctrl.sv
// ============================================================================
// kmst_ctrl
// Sequencer for loading, listing, sorting, union-find and result output.
// ============================================================================
module kmst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              final_edge,
    input  logic              cfg_valid,
    input  kmst_pkg::dp_stat_t stat,
    output kmst_pkg::dp_cmd_t  cmd,
    output logic              idle
);
    import kmst_pkg::*;

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_LIST  = 5'd2;
    localparam logic [4:0] ST_SCHK  = 5'd3;
    localparam logic [4:0] ST_SRD   = 5'd4;
    localparam logic [4:0] ST_SLD   = 5'd5;
    localparam logic [4:0] ST_SCAN  = 5'd6;
    localparam logic [4:0] ST_SW1   = 5'd7;
    localparam logic [4:0] ST_SW2   = 5'd8;
    localparam logic [4:0] ST_UINIT = 5'd9;
    localparam logic [4:0] ST_NEXT  = 5'd10;
    localparam logic [4:0] ST_URD   = 5'd11;
    localparam logic [4:0] ST_UCAP  = 5'd12;
    localparam logic [4:0] ST_FINDA = 5'd13;
    localparam logic [4:0] ST_FINDB = 5'd14;
    localparam logic [4:0] ST_UNITE = 5'd15;
    localparam logic [4:0] ST_EMIT  = 5'd16;
    localparam logic [4:0] ST_DONE  = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.cfg_we = cfg_valid;
                cmd.load   = in_valid;
                if (in_valid && final_edge)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_LIST;
                end
            end
            ST_LIST:
            begin
                cmd.sweep = 1'b1;
                cmd.list  = 1'b1;
                if (stat.sweep_done)
                    state_next = ST_SCHK;
            end
            ST_SCHK:
                state_next = stat.sort_more ? ST_SRD : ST_UINIT;
            ST_SRD:
            begin
                cmd.rd_i   = 1'b1;
                state_next = ST_SLD;
            end
            ST_SLD:
            begin
                cmd.cap_i  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                    state_next = ST_SW1;
            end
            ST_SW1:
            begin
                cmd.wr_best = stat.need_swap;
                state_next  = ST_SW2;
            end
            ST_SW2:
            begin
                cmd.wr_edge_i = stat.need_swap;
                cmd.next_i    = 1'b1;
                state_next    = ST_SCHK;
            end
            ST_UINIT:
            begin
                cmd.uf_init = 1'b1;
                state_next  = ST_NEXT;
            end
            ST_NEXT:
                state_next = stat.edges_left ? ST_URD : ST_DONE;
            ST_URD:
            begin
                cmd.rd_k   = 1'b1;
                state_next = ST_UCAP;
            end
            ST_UCAP:
            begin
                cmd.cap_k  = 1'b1;
                state_next = ST_FINDA;
            end
            ST_FINDA:
            begin
                cmd.find_a = 1'b1;
                if (stat.root_found)
                    state_next = ST_FINDB;
            end
            ST_FINDB:
            begin
                cmd.find_b = 1'b1;
                if (stat.root_found)
                    state_next = ST_UNITE;
            end
            ST_UNITE:
            begin
                cmd.unite = 1'b1;
                if (!stat.roots_differ)
                begin
                    cmd.next_k = 1'b1;
                    state_next = ST_NEXT;
                end
                else if (!stat.have_held)
                begin
                    cmd.take   = 1'b1;
                    cmd.next_k = 1'b1;
                    state_next = ST_NEXT;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_held = 1'b1;
                    cmd.take      = 1'b1;
                    cmd.next_k    = 1'b1;
                    state_next    = ST_NEXT;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/kmst_datapath.sv
// ============================================================================
// kmst_datapath
// Weight store, edge list memory, sort and union-find registers, output stage.
// ============================================================================
module kmst_datapath #(
    parameter int WEIGHT_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kmst_pkg::dp_cmd_t            cmd,
    output kmst_pkg::dp_stat_t           stat,
    input  logic [kmst_pkg::CFG_W-1:0]   cfg_data,
    input  logic [kmst_pkg::VERT_W-1:0]  end_a,
    input  logic [kmst_pkg::VERT_W-1:0]  end_b,
    input  logic [WEIGHT_BITS-1:0]       edge_weight,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [kmst_pkg::VERT_W-1:0]  low_vertex,
    output logic [kmst_pkg::VERT_W-1:0]  high_vertex,
    output logic [WEIGHT_BITS-1:0]       tree_weight,
    output logic                         last_of_tree,
    output logic                         tree_empty
);
    import kmst_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int SD    = 1 << (2 * VW);
    localparam int SW    = 2 * VW + 1;
    localparam int EDGES = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
    localparam int EW    = $clog2(EDGES + 1);
    localparam int AW    = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int GW    = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic [VW-1:0]          lo;
        logic [VW-1:0]          hi;
        logic [WEIGHT_BITS-1:0] w;
    } edge_t;

    // Configuration and vertex range.
    logic [CFG_W-1:0] vcount_reg;
    logic [CMP_W-1:0] n_vert;
    logic [CMP_W-1:0] ea_x;
    logic [CMP_W-1:0] eb_x;
    logic             load_ok;
    logic [VW-1:0]    ld_hi;
    logic [VW-1:0]    ld_lo;

    // Weight store, upper triangle addressed as {larger, smaller}.
    logic [WEIGHT_BITS-1:0] store [SD];
    logic [WEIGHT_BITS-1:0] st_rdata;
    logic                   st_we;
    logic [SW-2:0]          st_waddr;
    logic [WEIGHT_BITS-1:0] st_wdata;
    logic [SW-1:0]          ptr_reg;
    logic                   ptr_done;
    logic                   lpend_reg;
    logic [SW-2:0]          laddr_reg;
    logic [VW-1:0]          l_hi;
    logic [VW-1:0]          l_lo;
    logic                   append;

    // Edge list memory.
    edge_t         sorted [EDGES];
    edge_t         ed_rdata;
    edge_t         ed_wdata;
    logic          ed_we;
    logic [AW-1:0] ed_waddr;
    logic [AW-1:0] ed_raddr;

    logic [EW-1:0] count_reg;
    logic [EW-1:0] i_reg;
    logic [EW-1:0] j_reg;
    logic [EW-1:0] m_reg;
    logic [EW-1:0] sidx_reg;
    logic          spend_reg;
    logic          scan_issue;
    edge_t         edge_i_reg;
    edge_t         best_reg;

    // Union-find.
    logic [VW-1:0] parent [MAX_VERTICES];
    logic [VW-1:0] par_cur;
    logic [VW-1:0] cur_reg;
    logic [GW-1:0] guard_reg;
    logic [VW-1:0] ra_reg;
    logic [VW-1:0] rb_reg;
    logic [EW-1:0] k_reg;
    edge_t         edge_k_reg;
    edge_t         held_reg;
    logic          have_held_reg;
    logic          root_found;
    logic          out_valid_reg;
    logic          out_free;

    assign n_vert  = (CMP_W'(vcount_reg) > CMP_W'(MAX_VERTICES)) ?
                     CMP_W'(MAX_VERTICES) : CMP_W'(vcount_reg);
    assign ea_x    = CMP_W'(end_a);
    assign eb_x    = CMP_W'(end_b);
    assign load_ok = (end_a != end_b) && (ea_x < n_vert) && (eb_x < n_vert);
    assign ld_hi   = (end_a > end_b) ? VW'(end_a) : VW'(end_b);
    assign ld_lo   = (end_a > end_b) ? VW'(end_b) : VW'(end_a);

    assign ptr_done = ptr_reg[SW-1];
    assign st_we    = (cmd.load && load_ok) || (cmd.sweep && !ptr_done);
    assign st_waddr = cmd.load ? {ld_hi, ld_lo} : ptr_reg[SW-2:0];
    assign st_wdata = cmd.load ? edge_weight : '0;

    // Each sweep cycle reads an entry and zeroes it; the read returns old data.
    always_ff @(posedge clk)
    begin
        if (st_we)
            store[st_waddr] <= st_wdata;
        st_rdata <= store[ptr_reg[SW-2:0]];
    end

    assign l_hi   = laddr_reg[SW-2:VW];
    assign l_lo   = laddr_reg[VW-1:0];
    assign append = lpend_reg && (CMP_W'(l_hi) < n_vert) && (l_lo < l_hi) &&
                    (st_rdata != '0);

    assign scan_issue = cmd.scan && (j_reg < count_reg);

    always_comb
    begin
        ed_we    = append || cmd.wr_best || cmd.wr_edge_i;
        ed_waddr = m_reg[AW-1:0];
        ed_wdata = edge_i_reg;
        if (append)
        begin
            ed_waddr = count_reg[AW-1:0];
            ed_wdata = '{lo: l_lo, hi: l_hi, w: st_rdata};
        end
        else if (cmd.wr_best)
        begin
            ed_waddr = i_reg[AW-1:0];
            ed_wdata = best_reg;
        end
        if (cmd.rd_i)
            ed_raddr = i_reg[AW-1:0];
        else if (cmd.rd_k)
            ed_raddr = k_reg[AW-1:0];
        else
            ed_raddr = j_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ed_we)
            sorted[ed_waddr] <= ed_wdata;
        ed_rdata <= sorted[ed_raddr];
    end

    assign par_cur    = parent[cur_reg];
    assign root_found = (par_cur == cur_reg) || (guard_reg == GW'(MAX_VERTICES));

    always_ff @(posedge clk)
    begin
        if (cmd.uf_init)
        begin
            for (int v = 0; v < MAX_VERTICES; v++)
                parent[v] <= VW'(v);
        end
        else if (cmd.unite && (ra_reg != rb_reg))
            parent[ra_reg] <= rb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= CFG_RESET;
            ptr_reg       <= '0;
            lpend_reg     <= 1'b0;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            spend_reg     <= 1'b0;
            k_reg         <= '0;
            guard_reg     <= '0;
            have_held_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_we)
                vcount_reg <= cfg_data;
            if (cmd.start)
            begin
                ptr_reg   <= '0;
                count_reg <= '0;
                i_reg     <= '0;
            end
            else
            begin
                if (cmd.sweep && !ptr_done)
                    ptr_reg <= ptr_reg + 1'b1;
                if (append)
                    count_reg <= count_reg + 1'b1;
            end
            lpend_reg <= cmd.sweep && cmd.list && !ptr_done;

            if (cmd.cap_i)
                j_reg <= i_reg + 1'b1;
            else if (scan_issue)
                j_reg <= j_reg + 1'b1;
            spend_reg <= scan_issue;
            if (cmd.next_i)
                i_reg <= i_reg + 1'b1;

            if (cmd.uf_init)
                k_reg <= '0;
            else if (cmd.next_k)
                k_reg <= k_reg + 1'b1;

            if (cmd.cap_k || ((cmd.find_a || cmd.find_b) && root_found))
                guard_reg <= '0;
            else if (cmd.find_a || cmd.find_b)
                guard_reg <= guard_reg + 1'b1;

            if (cmd.uf_init || cmd.emit_final)
                have_held_reg <= 1'b0;
            else if (cmd.take)
                have_held_reg <= 1'b1;

            if (cmd.emit_held || cmd.emit_final)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        laddr_reg <= ptr_reg[SW-2:0];
        if (scan_issue)
            sidx_reg <= j_reg;
        if (cmd.cap_i)
        begin
            edge_i_reg <= ed_rdata;
            best_reg   <= ed_rdata;
            m_reg      <= i_reg;
        end
        else if (spend_reg && (ed_rdata.w < best_reg.w))
        begin
            best_reg <= ed_rdata;
            m_reg    <= sidx_reg;
        end

        if (cmd.cap_k)
        begin
            edge_k_reg <= ed_rdata;
            cur_reg    <= ed_rdata.lo;
        end
        else if (cmd.find_a && root_found)
        begin
            ra_reg  <= cur_reg;
            cur_reg <= edge_k_reg.hi;
        end
        else if (cmd.find_b && root_found)
            rb_reg <= cur_reg;
        else if (cmd.find_a || cmd.find_b)
            cur_reg <= par_cur;

        if (cmd.take)
            held_reg <= edge_k_reg;

        if (cmd.emit_held || (cmd.emit_final && have_held_reg))
        begin
            low_vertex   <= VERT_W'(held_reg.lo);
            high_vertex  <= VERT_W'(held_reg.hi);
            tree_weight  <= held_reg.w;
            last_of_tree <= cmd.emit_final;
            tree_empty   <= 1'b0;
        end
        else if (cmd.emit_final)
        begin
            low_vertex   <= '0;
            high_vertex  <= '0;
            tree_weight  <= '0;
            last_of_tree <= 1'b1;
            tree_empty   <= 1'b1;
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        stat.sweep_done   = ptr_done && !lpend_reg;
        stat.sort_more    = ((EW + 1)'(i_reg) + 1'b1) < (EW + 1)'(count_reg);
        stat.scan_done    = !spend_reg && (j_reg == count_reg);
        stat.need_swap    = (best_reg.w != edge_i_reg.w);
        stat.edges_left   = (k_reg < count_reg);
        stat.root_found   = root_found;
        stat.roots_differ = (ra_reg != rb_reg);
        stat.have_held    = have_held_reg;
        stat.out_free     = out_free;
    end

endmodule

FILE: hdl/kruskal_min_spanning_tree_unit.sv
// ============================================================================
// kruskal_min_spanning_tree_unit
// Minimum spanning forest of a small weighted undirected graph.
// ============================================================================
// Edges enter on the input channel (in_valid / in_stall), one transaction per
// cycle while the unit is loading; each valid edge writes one store entry.
// An edge with final_edge set starts the computation and in_stall rises until
// every tree edge has been handed over. The computation lists the store in
// one sweep (this sweep also clears the store), sorts the E listed edges by
// selection sort through the edge-list memory, then runs union-find on
// each edge in sorted order, held up by output stalls.
// Tree edges leave on the output channel (out_valid / out_stall) in order of
// acceptance; last_of_tree marks the final one, and a graph without any tree
// edge gives one transaction with tree_empty set. A stalled output holds its
// transaction while the unit waits to deliver the next.
// vertex_count is written on the cfg channel (cfg_valid / cfg_ready), taken
// while the unit is loading. After reset the unit clears the store before
// accepting edges.
// ============================================================================
module kruskal_min_spanning_tree_unit #(
    parameter int WEIGHT_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [kmst_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [kmst_pkg::VERT_W-1:0]  end_a,
    input  logic [kmst_pkg::VERT_W-1:0]  end_b,
    input  logic [WEIGHT_BITS-1:0]       edge_weight,
    input  logic                         final_edge,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [kmst_pkg::VERT_W-1:0]  low_vertex,
    output logic [kmst_pkg::VERT_W-1:0]  high_vertex,
    output logic [WEIGHT_BITS-1:0]       tree_weight,
    output logic                         last_of_tree,
    output logic                         tree_empty
);
    import kmst_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     idle;

    assign in_stall  = !idle;
    assign cfg_ready = idle;

    kmst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_edge (final_edge),
        .cfg_valid  (cfg_valid),
        .stat       (stat),
        .cmd        (cmd),
        .idle       (idle)
    );

    kmst_datapath #(
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_data     (cfg_data),
        .end_a        (end_a),
        .end_b        (end_b),
        .edge_weight  (edge_weight),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .low_vertex   (low_vertex),
        .high_vertex  (high_vertex),
        .tree_weight  (tree_weight),
        .last_of_tree (last_of_tree),
        .tree_empty   (tree_empty)
    );

endmodule

FILE: hdl/kmst_checker.sv
// ============================================================================
// kmst_checker
// Port-level checks of the minimum spanning tree unit.
// ============================================================================
module kmst_checker #(
    parameter int WEIGHT_BITS = 8
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [kmst_pkg::VERT_W-1:0]  low_vertex,
    input logic [kmst_pkg::VERT_W-1:0]  high_vertex,
    input logic [WEIGHT_BITS-1:0]       tree_weight,
    input logic                         last_of_tree,
    input logic                         tree_empty
);

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(low_vertex) &&
        $stable(high_vertex) && $stable(tree_weight) &&
        $stable(last_of_tree) && $stable(tree_empty))
        else $error("stalled result changed");

    // An empty tree is one lone transaction with zero fields.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tree_empty |-> last_of_tree && low_vertex == '0 &&
        high_vertex == '0 && tree_weight == '0)
        else $error("empty result malformed");

    // Tree edges are ordered pairs with a nonzero weight.
    a_edge_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tree_empty |-> low_vertex < high_vertex &&
        tree_weight != '0)
        else $error("tree edge malformed");

    // Results appear only while the unit holds off new edges or just after.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without computation");

endmodule

bind kruskal_min_spanning_tree_unit kmst_checker #(
    .WEIGHT_BITS (WEIGHT_BITS)
) u_kmst_checker (.*);

FILE: sim/kruskal_min_spanning_tree_unit_tb.sv
// ============================================================================
// kruskal_min_spanning_tree_unit_tb
// Self-checking testbench for the minimum spanning tree unit.
// ============================================================================
// Edges are loaded into the unit and the graph is closed with a final edge.
// A behavioral model of the unit predicts the tree edges of each graph: it
// keeps its own weight store, lists and sorts the edges, and runs union-find.
// Every output transaction is checked field by field against the oldest
// predicted tree edge. Both channels see random idle cycles and stalls.
// ============================================================================
`timescale 1ns / 100ps

module kruskal_min_spanning_tree_unit_tb;
    import kmst_pkg::*;

    localparam int MAX_V      = 32;
    localparam int MAX_E      = (MAX_V * (MAX_V - 1)) / 2;
    localparam int CYCLE_CAP  = 3000000;
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic [VERT_W-1:0] lo;
        logic [VERT_W-1:0] hi;
        logic [7:0]        wt;
        logic              last;
        logic              empty;
    } tree_edge_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [VERT_W-1:0]  end_a;
    logic [VERT_W-1:0]  end_b;
    logic [7:0]         edge_weight;
    logic               final_edge;
    logic               out_valid;
    logic               out_stall;
    logic [VERT_W-1:0]  low_vertex;
    logic [VERT_W-1:0]  high_vertex;
    logic [7:0]         tree_weight;
    logic               last_of_tree;
    logic               tree_empty;

    // Model state.
    logic [7:0]  model_store [MAX_V][MAX_V];
    int unsigned model_vcount;
    int unsigned model_parent [MAX_V];
    tree_edge_t  tree_edges_due [$];

    int  fail_count;
    int  cycle_count;
    bit  sender_gaps;
    bit  receiver_stalls;
    int  hold_off_cycles;
    int  stall_left;

    kruskal_min_spanning_tree_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .end_a        (end_a),
        .end_b        (end_b),
        .edge_weight  (edge_weight),
        .final_edge   (final_edge),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .low_vertex   (low_vertex),
        .high_vertex  (high_vertex),
        .tree_weight  (tree_weight),
        .last_of_tree (last_of_tree),
        .tree_empty   (tree_empty)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("kruskal_min_spanning_tree_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic int unsigned find_set(input int unsigned v);
        int unsigned guard;
        guard = 0;
        while (model_parent[v] != v && guard < MAX_V)
        begin
            v = model_parent[v];
            guard++;
        end
        return v;
    endfunction

    // Applies one edge to the model and, on a final edge, predicts the tree.
    task automatic predict_tree(input int unsigned a, input int unsigned b,
                                input logic [7:0] w, input bit fin);
        int unsigned n;
        int unsigned cnt;
        int unsigned m;
        int unsigned ra;
        int unsigned rb;
        int unsigned taken;
        int unsigned e_lo [MAX_E];
        int unsigned e_hi [MAX_E];
        logic [7:0]  e_wt [MAX_E];
        int unsigned t_lo;
        int unsigned t_hi;
        logic [7:0]  t_wt;
        tree_edge_t  te;
        n = (model_vcount > MAX_V) ? MAX_V : model_vcount;
        if (a != b && a < n && b < n)
        begin
            model_store[a][b] = w;
            model_store[b][a] = w;
        end
        if (!fin)
            return;
        cnt = 0;
        for (int unsigned i = 0; i < n; i++)
            for (int unsigned j = 0; j < i; j++)
                if (model_store[i][j] != 0)
                begin
                    e_lo[cnt] = j;
                    e_hi[cnt] = i;
                    e_wt[cnt] = model_store[i][j];
                    cnt++;
                end
        // Selection sort that leaves equal weights where they are.
        for (int unsigned i = 0; i + 1 < cnt; i++)
        begin
            m = i;
            for (int unsigned j = i + 1; j < cnt; j++)
                if (e_wt[j] < e_wt[m])
                    m = j;
            if (e_wt[i] != e_wt[m])
            begin
                t_lo = e_lo[i]; t_hi = e_hi[i]; t_wt = e_wt[i];
                e_lo[i] = e_lo[m]; e_hi[i] = e_hi[m]; e_wt[i] = e_wt[m];
                e_lo[m] = t_lo; e_hi[m] = t_hi; e_wt[m] = t_wt;
            end
        end
        for (int unsigned i = 0; i < MAX_V; i++)
            model_parent[i] = i;
        taken = 0;
        for (int unsigned i = 0; i < cnt; i++)
        begin
            ra = find_set(e_lo[i]);
            rb = find_set(e_hi[i]);
            if (ra != rb)
            begin
                model_parent[ra] = rb;
                te.lo    = VERT_W'(e_lo[i]);
                te.hi    = VERT_W'(e_hi[i]);
                te.wt    = e_wt[i];
                te.last  = 1'b0;
                te.empty = 1'b0;
                tree_edges_due.push_back(te);
                taken++;
            end
        end
        for (int unsigned i = 0; i < MAX_V; i++)
            for (int unsigned j = 0; j < MAX_V; j++)
                model_store[i][j] = 8'd0;
        if (taken == 0)
        begin
            te = '0;
            te.last  = 1'b1;
            te.empty = 1'b1;
            tree_edges_due.push_back(te);
        end
        else
        begin
            tree_edges_due[tree_edges_due.size() - 1].last = 1'b1;
        end
    endtask

    // Offers one edge and waits for its transaction, then maybe idles.
    task automatic send_edge(input int unsigned a, input int unsigned b,
                             input int unsigned w, input bit fin);
        int unsigned gap;
        int unsigned pick;
        @(negedge clk);
        in_valid    = 1'b1;
        end_a       = a[VERT_W-1:0];
        end_b       = b[VERT_W-1:0];
        edge_weight = w[7:0];
        final_edge  = fin;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        predict_tree(a[VERT_W-1:0], b[VERT_W-1:0], w[7:0], fin);
        if (sender_gaps)
        begin
            pick = $urandom_range(0, 99);
            gap = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (tree_edges_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_vertex_count(input int unsigned v);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = v[CFG_W-1:0];
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        model_vcount = v[CFG_W-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver stall pattern, with an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall = 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left = stall_left - 1;
        end
        else if (receiver_stalls && $urandom_range(0, 99) < 25)
        begin
            out_stall = 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        tree_edge_t exp_e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tree_edges_due.size() == 0)
            begin
                $display("%0t: unexpected tree edge lo=%0d hi=%0d w=%0d", $realtime,
                         low_vertex, high_vertex, tree_weight);
                fail_count++;
            end
            else
            begin
                exp_e = tree_edges_due.pop_front();
                if (low_vertex !== exp_e.lo)
                begin
                    $display("%0t: low_vertex expected %0d got %0d", $realtime, exp_e.lo,
                             low_vertex);
                    fail_count++;
                end
                if (high_vertex !== exp_e.hi)
                begin
                    $display("%0t: high_vertex expected %0d got %0d", $realtime, exp_e.hi,
                             high_vertex);
                    fail_count++;
                end
                if (tree_weight !== exp_e.wt)
                begin
                    $display("%0t: tree_weight expected %0d got %0d", $realtime, exp_e.wt,
                             tree_weight);
                    fail_count++;
                end
                if (last_of_tree !== exp_e.last)
                begin
                    $display("%0t: last_of_tree expected %0b got %0b", $realtime, exp_e.last,
                             last_of_tree);
                    fail_count++;
                end
                if (tree_empty !== exp_e.empty)
                begin
                    $display("%0t: tree_empty expected %0b got %0b", $realtime, exp_e.empty,
                             tree_empty);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        write_vertex_count(32);
        send_edge(0, 31, 255, 0);
        send_edge(31, 30, 1, 0);
        send_edge(0, 1, 7, 0);
        send_edge(1, 0, 3, 0);         // overwrite of the same pair
        send_edge(5, 5, 9, 0);         // self-loop
        send_edge(2, 3, 0, 0);         // zero weight adds nothing
        send_edge(30, 0, 200, 0);      // closes a cycle
        send_edge(1, 30, 200, 1);
        send_edge(4, 4, 12, 1);        // empty graph
        send_edge(3, 2, 9, 0);
        send_edge(2, 3, 0, 1);         // zero weight removes the edge
        write_vertex_count(63);        // saturates to the full size
        send_edge(21, 10, 5, 0);
        send_edge(10, 21, 5, 1);
        write_vertex_count(0);
        send_edge(0, 1, 4, 1);
        write_vertex_count(1);
        send_edge(0, 1, 4, 1);
        write_vertex_count(4);
        send_edge(0, 4, 4, 0);         // endpoint out of range
        send_edge(0, 1, 5, 0);
        send_edge(1, 2, 5, 0);         // equal weights keep list order
        send_edge(0, 2, 5, 0);
        send_edge(2, 3, 5, 1);
        // Edges stored under a larger count, then the count is lowered.
        write_vertex_count(32);
        send_edge(1, 2, 8, 0);
        send_edge(2, 20, 2, 0);
        write_vertex_count(3);
        send_edge(0, 1, 6, 1);
    endtask

    task automatic send_random_graph(input int unsigned nv, input int unsigned n_edges);
        int unsigned a;
        int unsigned b;
        int unsigned w;
        int unsigned pick;
        for (int unsigned k = 0; k < n_edges; k++)
        begin
            pick = $urandom_range(0, 99);
            a = $urandom_range(0, nv - 1);
            b = $urandom_range(0, nv - 1);
            w = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
            if (pick < 6)
                b = a;
            else if (pick < 11)
                w = 0;
            else if (pick < 16)
            begin
                a = $urandom_range(0, 31);
                b = $urandom_range(0, 31);
            end
            send_edge(a, b, w, k + 1 == n_edges);
        end
    endtask

    task automatic test_random();
        int unsigned sent;
        int unsigned nv;
        int unsigned ne;
        sent = 0;
        while (sent < 340)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                nv = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(2, 12);
                write_vertex_count(nv);
            end
            nv = (model_vcount == 0) ? 1 : (model_vcount > MAX_V ? MAX_V : model_vcount);
            if (nv < 2)
                nv = 2;
            ne = $urandom_range(1, 3 * nv);
            if (ne > 40)
                ne = 40;
            sender_gaps     = ($urandom_range(0, 4) != 0);
            receiver_stalls = ($urandom_range(0, 4) != 0);
            send_random_graph(nv, ne);
            sent += ne;
        end
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // A spanning path over all vertices yields the largest tree; the receiver
    // holds off long enough that the unit must keep it waiting.
    task automatic test_backpressure();
        write_vertex_count(32);
        hold_off_cycles = 3000;
        for (int unsigned k = 0; k < MAX_V - 1; k++)
            send_edge(k, k + 1, $urandom_range(1, 255), 0);
        send_edge(0, 31, 255, 1);
        send_edge(3, 9, 7, 0);
        send_edge(9, 3, 7, 1);
        wait_drained();
        send_edge(0, 1, 1, 1);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        end_a           = '0;
        end_b           = '0;
        edge_weight     = '0;
        final_edge      = 1'b0;
        out_stall       = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_off_cycles = 0;
        stall_left      = 0;
        model_vcount    = CFG_RESET;
        for (int i = 0; i < MAX_V; i++)
            for (int j = 0; j < MAX_V; j++)
                model_store[i][j] = 8'd0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        wait_drained();
        if (fail_count == 0 && tree_edges_due.size() == 0)
            $display("kruskal_min_spanning_tree_unit_tb OK");
        else
            $display("kruskal_min_spanning_tree_unit_tb NOT OK");
        $finish;
    end

endmodule
